[design/sas_pkg.sv]
`default_nettype none

package sas_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = 32;
    localparam int POS_W       = 9;

    // Request codes
    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_WAIT,
        ST_MATCH,
        ST_SHIFT,
        ST_MOVE,
        ST_DONE
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_req;
        logic rd_mid;
        logic step;
        logic rd_lo;
        logic decide;
        logic init_shift;
        logic rd_shift;
        logic wr_shift;
        logic wr_new;
        logic load_out;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic lo_lt_hi;
        logic insert_ok;
        logic shift_left;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

[design/sas_dpath.sv]
`default_nettype none

module sas_dpath
    import sas_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cmd_t              cmd,
    output status_t                status,
    input  wire logic              s_req_type,
    input  wire logic [ADDR_W-1:0] s_address,
    input  wire logic              s_exact,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [POS_W-1:0]       m_position,
    output logic                   m_found,
    output logic                   m_added,
    output logic                   m_full_res
);

    logic [ADDR_W-1:0] mem [TABLE_DEPTH];
    logic [ADDR_W-1:0] rdata_reg;

    logic [ADDR_W-1:0] addr_reg;
    logic              req_type_reg;
    logic              exact_reg;
    logic [CNT_W-1:0]  lo_reg;
    logic [CNT_W-1:0]  hi_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  j_reg;
    logic              match_reg;
    logic              added_reg;
    logic              full_reg;

    logic              m_valid_reg;
    logic [POS_W-1:0]  m_position_reg;
    logic              m_found_reg;
    logic              m_added_reg;
    logic              m_full_res_reg;

    logic [CNT_W-1:0]  mid;
    logic [CNT_W-1:0]  jm1;
    logic [IDX_W-1:0]  rd_addr;
    logic              rd_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [ADDR_W-1:0] wr_data;
    logic              wr_en;
    logic              below;
    logic              match_now;
    logic              room;
    logic              is_insert;

    // Search midpoint and shift source
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign jm1 = j_reg - 1'b1;

    assign below     = rdata_reg < addr_reg;
    assign match_now = (lo_reg < count_reg) && (rdata_reg == addr_reg);
    assign room      = count_reg < CNT_W'(TABLE_DEPTH);
    assign is_insert = req_type_reg == REQ_INSERT;

    // Pick the read address
    always_comb begin
        if (cmd.rd_shift) begin
            rd_addr = jm1[IDX_W-1:0];
        end else if (cmd.rd_lo) begin
            rd_addr = lo_reg[IDX_W-1:0];
        end else begin
            rd_addr = mid[IDX_W-1:0];
        end
    end
    assign rd_en = cmd.rd_mid | cmd.rd_lo | cmd.rd_shift;

    // Pick the write address and word
    assign wr_en   = cmd.wr_shift | cmd.wr_new;
    assign wr_addr = cmd.wr_new ? lo_reg[IDX_W-1:0] : j_reg[IDX_W-1:0];
    assign wr_data = cmd.wr_new ? addr_reg : rdata_reg;

    // Table storage, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Capture the request word
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            addr_reg     <= s_address;
            req_type_reg <= s_req_type;
            exact_reg    <= s_exact;
        end
    end

    // Search bounds, entry count and shift pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_reg    <= '0;
            hi_reg    <= '0;
            count_reg <= '0;
            j_reg     <= '0;
        end else begin
            if (cmd.load_req) begin
                lo_reg <= '0;
                hi_reg <= count_reg;
            end else if (cmd.step) begin
                if (below) begin
                    lo_reg <= mid + 1'b1;
                end else begin
                    hi_reg <= mid;
                end
            end
            if (cmd.init_shift) begin
                j_reg <= count_reg;
            end else if (cmd.wr_shift) begin
                j_reg <= jm1;
            end
            if (cmd.wr_new) begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Record the outcome of the search
    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            match_reg <= match_now;
            added_reg <= is_insert && !match_now && room;
            full_reg  <= is_insert && !match_now && !room;
        end
    end

    // Result register, frees the input side while the word waits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_position_reg <= POS_W'(lo_reg);
            m_found_reg    <= is_insert ? match_reg : (exact_reg && match_reg);
            m_added_reg    <= added_reg;
            m_full_res_reg <= full_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_position = m_position_reg;
    assign m_found    = m_found_reg;
    assign m_added    = m_added_reg;
    assign m_full_res = m_full_res_reg;

    assign status.lo_lt_hi   = lo_reg < hi_reg;
    assign status.insert_ok  = is_insert && !match_now && room;
    assign status.shift_left = j_reg > lo_reg;
    assign status.out_free   = !m_valid_reg || m_ready;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != $past(count_reg) |-> count_reg == $past(count_reg) + 1'b1)
        else $error("entry count moved by other than one");

    a_bounds_order: assert property (@(posedge aclk) disable iff (!aresetn)
        lo_reg <= hi_reg && hi_reg <= count_reg)
        else $error("search bounds out of order");

    a_shift_above: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_shift |-> j_reg > lo_reg)
        else $error("shift write at or below insert position");

endmodule

`default_nettype wire

[design/sas_ctrl.sv]
`default_nettype none

module sas_ctrl
    import sas_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_SEARCH;
            ST_SEARCH: state_next = status.lo_lt_hi ? ST_WAIT : ST_MATCH;
            ST_WAIT:   state_next = ST_SEARCH;
            ST_MATCH:  state_next = status.insert_ok ? ST_SHIFT : ST_DONE;
            ST_SHIFT:  state_next = status.shift_left ? ST_MOVE : ST_DONE;
            ST_MOVE:   state_next = ST_SHIFT;
            ST_DONE:   if (status.out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.load_req = s_valid;
            end
            ST_SEARCH: begin
                cmd.rd_mid = status.lo_lt_hi;
                cmd.rd_lo  = !status.lo_lt_hi;
            end
            ST_WAIT: begin
                cmd.step = 1'b1;
            end
            ST_MATCH: begin
                cmd.decide     = 1'b1;
                cmd.init_shift = status.insert_ok;
            end
            ST_SHIFT: begin
                cmd.rd_shift = status.shift_left;
                cmd.wr_new   = !status.shift_left;
            end
            ST_MOVE: begin
                cmd.wr_shift = 1'b1;
            end
            ST_DONE: begin
                cmd.load_out = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // Checks
    a_accept_search: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_SEARCH)
        else $error("accepted word did not start a search");

    a_one_read: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.rd_mid, cmd.rd_lo, cmd.rd_shift}))
        else $error("more than one table read requested");

    a_move_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MOVE |-> $past(cmd.rd_shift))
        else $error("shift write without preceding read");

endmodule

`default_nettype wire

[design/sorted_address_set_core.sv]
// Sorted address set: an ascending table of up to TABLE_DEPTH (256) distinct
// 32-bit addresses in a two-port RAM, empty after reset. A lookup returns
// the lower-bound position (count of stored entries below the address) and,
// with exact set, whether the entry there matches. An insert finds the same
// position and, if the address is absent and there is room, stores it there
// and moves later entries up; an absent address with the table full is
// dropped with full_res set. One word is worked at a time. Timing is set by
// the RAM's single registered read port: each halving step of the binary
// search reads the midpoint in SEARCH and moves a bound in WAIT, and an
// insert that stores its address moves each later entry up with a read in
// SHIFT and a write in MOVE. The result sits in an output register, so the
// next word is taken while a result still waits.
`default_nettype none

module sorted_address_set_core
    import sas_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_req_type,
    input  wire logic [ADDR_W-1:0] s_address,
    input  wire logic              s_exact,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [POS_W-1:0]       m_position,
    output logic                   m_found,
    output logic                   m_added,
    output logic                   m_full_res
);

    cmd_t    cmd;
    status_t status;

    sas_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sas_dpath u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .s_req_type (s_req_type),
        .s_address  (s_address),
        .s_exact    (s_exact),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_position (m_position),
        .m_found    (m_found),
        .m_added    (m_added),
        .m_full_res (m_full_res)
    );

endmodule

`default_nettype wire

[test/sas_checker.sv]
module sas_checker
    import sas_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic              s_req_type,
    input  logic [ADDR_W-1:0] s_address,
    input  logic              s_exact,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [POS_W-1:0]  m_position,
    input  logic              m_found,
    input  logic              m_added,
    input  logic              m_full_res,
    output int                fail_count,
    output int                pending_count,
    output int                checked_count,
    output int                stored_count,
    output int                dropped_count,
    output int                hit_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             found;
        logic             added;
        logic             full_res;
    } sas_result_t;

    // Shadow copy of the sorted table; only the first shadow_count entries are valid
    logic [ADDR_W-1:0] shadow_entries [TABLE_DEPTH];
    int                shadow_count = 0;
    sas_result_t       pending_results [$];

    // Print one line per mismatch (up to a cap) and count every one
    task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                   input logic [ADDR_W-1:0] want);
        if (fail_count < PRINT_LIMIT)
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
                     $realtime, what, got, want);
        fail_count++;
    endtask

    // Search the shadow table, apply an insert to it, and return the expected word
    function automatic sas_result_t apply_request(input logic req_type,
                                                  input logic [ADDR_W-1:0] addr,
                                                  input logic exact);
        int          lo;
        int          hi;
        int          mid;
        logic        hit;
        sas_result_t res;
        lo = 0;
        hi = shadow_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (shadow_entries[mid] < addr)
                lo = mid + 1;
            else
                hi = mid;
        end
        hit = (lo < shadow_count) && (shadow_entries[lo] == addr);
        res = '0;
        res.position = lo[POS_W-1:0];
        if (req_type == REQ_INSERT) begin
            res.found = hit;
            if (!hit) begin
                if (shadow_count >= TABLE_DEPTH) begin
                    res.full_res = 1'b1;
                end else begin
                    // Move the tail up by one and drop the new address into the hole
                    for (int i = shadow_count; i > lo; i--)
                        shadow_entries[i] = shadow_entries[i-1];
                    shadow_entries[lo] = addr;
                    shadow_count++;
                    res.added = 1'b1;
                end
            end
        end else begin
            res.found = exact && hit;
        end
        return res;
    endfunction

    // Predict on every accepted request word, compare on every accepted result word
    always @(posedge aclk) begin
        sas_result_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                pending_results.push_back(apply_request(s_req_type, s_address, s_exact));
            if (m_valid && m_ready) begin
                checked_count++;
                if (pending_results.size() == 0) begin
                    report_mismatch("result with no request pending",
                                    ADDR_W'(m_position), '0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_position !== want.position)
                        report_mismatch("position", ADDR_W'(m_position),
                                        ADDR_W'(want.position));
                    if (m_found !== want.found)
                        report_mismatch("found", ADDR_W'(m_found), ADDR_W'(want.found));
                    if (m_added !== want.added)
                        report_mismatch("added", ADDR_W'(m_added), ADDR_W'(want.added));
                    if (m_full_res !== want.full_res)
                        report_mismatch("full_res", ADDR_W'(m_full_res),
                                        ADDR_W'(want.full_res));
                    stored_count  += int'(want.added);
                    dropped_count += int'(want.full_res);
                    hit_count     += int'(want.found);
                end
            end
            pending_count = pending_results.size();
        end
    end

endmodule

[test/tb_top.sv]
module tb_top
    import sas_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS    = 680;
    localparam int FILL_ITEMS      = 550;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int HOLD_OFF_AFTER  = 120;
    localparam int DRAIN_CYCLES    = 64;
    localparam int CYCLE_LIMIT     = 3_000_000;

    typedef struct packed {
        logic              req_type;
        logic [ADDR_W-1:0] addr;
        logic              exact;
    } request_t;

    // Hand-picked opening sequence: empty table, ends of the table, duplicates, bit patterns
    localparam request_t DIRECTED_REQS [0:19] = '{
        '{REQ_LOOKUP, 32'h0000_0000, 1'b0},
        '{REQ_LOOKUP, 32'hFFFF_FFFF, 1'b1},
        '{REQ_INSERT, 32'h8000_0000, 1'b0},
        '{REQ_LOOKUP, 32'hFFFF_FFFF, 1'b1},
        '{REQ_INSERT, 32'h8000_0000, 1'b1},
        '{REQ_INSERT, 32'h0000_0000, 1'b0},
        '{REQ_INSERT, 32'hFFFF_FFFF, 1'b0},
        '{REQ_INSERT, 32'h7FFF_FFFF, 1'b1},
        '{REQ_INSERT, 32'h8000_0001, 1'b0},
        '{REQ_LOOKUP, 32'h8000_0000, 1'b1},
        '{REQ_LOOKUP, 32'h8000_0000, 1'b0},
        '{REQ_LOOKUP, 32'h7FFF_FFFE, 1'b1},
        '{REQ_LOOKUP, 32'hFFFF_FFFF, 1'b1},
        '{REQ_LOOKUP, 32'h0000_0000, 1'b1},
        '{REQ_INSERT, 32'h0000_0000, 1'b1},
        '{REQ_INSERT, 32'hFFFF_FFFF, 1'b0},
        '{REQ_INSERT, 32'h5555_5555, 1'b0},
        '{REQ_INSERT, 32'hAAAA_AAAA, 1'b1},
        '{REQ_LOOKUP, 32'hAAAA_AAAA, 1'b1},
        '{REQ_LOOKUP, 32'h0000_0001, 1'b1}
    };

    logic              aclk       = 1'b0;
    logic              aresetn    = 1'b0;
    logic              s_valid    = 1'b0;
    logic              s_ready;
    logic              s_req_type = 1'b0;
    logic [ADDR_W-1:0] s_address  = '0;
    logic              s_exact    = 1'b0;
    logic              m_valid;
    logic              m_ready    = 1'b0;
    logic [POS_W-1:0]  m_position;
    logic              m_found;
    logic              m_added;
    logic              m_full_res;

    int fail_count;
    int pending_count;
    int checked_count;
    int stored_count;
    int dropped_count;
    int hit_count;

    int cycle_count      = 0;
    int stall_cycles     = 0;
    int inserts_sent     = 0;
    int lookups_sent     = 0;
    logic [ADDR_W-1:0] inserted_addrs [$];

    sorted_address_set_core dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_address  (s_address),
        .s_exact    (s_exact),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_position (m_position),
        .m_found    (m_found),
        .m_added    (m_added),
        .m_full_res (m_full_res)
    );

    sas_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_address     (s_address),
        .s_exact       (s_exact),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_position    (m_position),
        .m_found       (m_found),
        .m_added       (m_added),
        .m_full_res    (m_full_res),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count),
        .stored_count  (stored_count),
        .dropped_count (dropped_count),
        .hit_count     (hit_count)
    );

    initial begin : clock_gen
        forever #6 aclk = ~aclk;
    end

    initial begin : reset_gen
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Count cycles where the block pushes back on a waiting request word
    always @(posedge aclk) begin
        if (aresetn && s_valid && !s_ready)
            stall_cycles++;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int idle_cycles(input int none_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < none_pct)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(12, 60);
    endfunction

    // Mix of random, low, high, present and neighbor addresses
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [ADDR_W-1:0] base;
        base = inserted_addrs.size() != 0 ?
               inserted_addrs[$urandom_range(0, inserted_addrs.size() - 1)] : $urandom;
        case ($urandom_range(0, 9)) inside
            [0:2]:   return $urandom;
            3:       return $urandom_range(0, 1023);
            4:       return 32'hFFFF_FFFF - $urandom_range(0, 1023);
            5, 6:    return base;
            7:       return base + 1;
            8:       return base - 1;
            default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        endcase
    endfunction

    // Offer one request word and hold it until the block takes it
    task automatic send_request(input request_t req);
        s_valid    <= 1'b1;
        s_req_type <= req.req_type;
        s_address  <= req.addr;
        s_exact    <= req.exact;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (req.req_type == REQ_INSERT) begin
            inserts_sent++;
            inserted_addrs.push_back(req.addr);
        end else begin
            lookups_sent++;
        end
    endtask

    // Drop valid for a random gap unless in a burst
    task automatic pause_sender(input bit burst);
        int gap;
        gap = burst ? 0 : idle_cycles(55);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Result side: random stalls, long ready stretches, one long hold-off
    initial begin : result_sink
        int hold;
        bit held_off;
        held_off = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (!held_off && checked_count >= HOLD_OFF_AFTER) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else if ($urandom_range(0, 99) < 30) begin
                hold = idle_cycles(0);
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(50, 150)) @(posedge aclk);
            else
                repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_count);
        $display("FAILURE");
        $finish;
    end

    // Request side: directed opening, then random traffic that fills the table
    initial begin : stimulus
        request_t req;
        bit       burst;
        int       insert_pct;
        burst = 1'b0;
        do @(posedge aclk); while (!aresetn);

        foreach (DIRECTED_REQS[i]) begin
            send_request(DIRECTED_REQS[i]);
            pause_sender(i % 2 == 0);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0)
                burst = ($urandom_range(0, 3) == 0);
            insert_pct   = (n < FILL_ITEMS) ? 75 : 50;
            req.req_type = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_LOOKUP;
            req.addr     = pick_address();
            req.exact    = 1'($urandom_range(0, 1));
            send_request(req);
            pause_sender(burst);
        end
        s_valid <= 1'b0;

        // Let the checker log the last word, wait out every result, then a short tail
        @(posedge aclk);
        while (pending_count != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d requests (%0d inserts, %0d lookups), checked %0d results",
                 inserts_sent + lookups_sent, inserts_sent, lookups_sent, checked_count);
        $display("%0d stored, %0d dropped on a full table, %0d matches, %0d input stall cycles",
                 stored_count, dropped_count, hit_count, stall_cycles);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[sorted_address_set_core.f]
design/sas_pkg.sv
design/sas_dpath.sv
design/sas_ctrl.sv
design/sorted_address_set_core.sv
test/sas_checker.sv
test/tb_top.sv
